// File: rtl/uhsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unit hydrograph sediment router package
// Shared constants, codes and arithmetic helpers of the router.
// ----------------------------------------------------------------------------
package uhsr_pkg;

  localparam int DefCells        = 1024;
  localparam int DefLags         = 32;
  localparam int DefMaxSubbasins = 63;

  localparam int SumDepth = 64;
  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_STEP = 2'd1,
    FUNC_END  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [11:0] {
    ST_CLR  = 12'b0000_0000_0001,
    ST_IDLE = 12'b0000_0000_0010,
    ST_SRD  = 12'b0000_0000_0100,
    ST_SMUL = 12'b0000_0000_1000,
    ST_SWR  = 12'b0000_0001_0000,
    ST_BRD  = 12'b0000_0010_0000,
    ST_BWR  = 12'b0000_0100_0000,
    ST_TRD  = 12'b0000_1000_0000,
    ST_TACC = 12'b0001_0000_0000,
    ST_ORD  = 12'b0010_0000_0000,
    ST_OLD  = 12'b0100_0000_0000,
    ST_EMIT = 12'b1000_0000_0000
  } state_e;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? Sat32 : s[31:0];
  endfunction

endpackage

// File: rtl/unit_hydrograph_sediment_router.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unit hydrograph sediment router
// Routes cell sediment yields through per-cell unit hydrographs and sums them.
// ----------------------------------------------------------------------------
// A load writes the weight store as it is accepted. A step reads, multiplies and writes
// back each slot (SRD, SMUL, SWR), updates its subbasin sum (BRD, BWR) if in range, and
// waits in EMIT. An end transaction totals the sums (TRD, TACC), then reports each (ORD,
// OLD, EMIT). One transaction is processed at a time; the input stalls until it completes.
// After reset a clearing pass zeroes both stores.
module unit_hydrograph_sediment_router #(
  parameter int CELLS         = uhsr_pkg::DefCells,
  parameter int LAGS          = uhsr_pkg::DefLags,
  parameter int MAX_SUBBASINS = uhsr_pkg::DefMaxSubbasins
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [9:0]  cell_req_i,
  input  logic [4:0]  lag_i,
  input  logic [15:0] weight_i,
  input  logic [5:0]  subbasin_i,
  input  logic [31:0] sed_yield_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [9:0]  index_o,
  output logic [31:0] amount_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i
);

  localparam int Depth = CELLS * LAGS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LagW  = (LAGS > 1) ? $clog2(LAGS) : 1;

  uhsr_pkg::state_e state_q;

  logic [AddrW-1:0] clr_q;
  logic [AddrW-1:0] base_q;
  logic [LagW-1:0]  jcnt_q;
  logic [9:0]       cell_q;
  logic [5:0]       sb_q;
  logic [31:0]      yld_q;
  logic [31:0]      old_q;
  logic [31:0]      prod_q;
  logic [31:0]      head_q;
  logic [31:0]      total_q;
  logic [5:0]       i_q;
  logic [5:0]       nsb_q;
  logic [uhsr_pkg::SumDepth-1:0] bs_valid_q;

  logic        kind_q;
  logic [9:0]  index_q;
  logic [31:0] amount_q;
  logic        last_q;

  logic [31:0] dly_mem [Depth];
  logic [15:0] wt_mem  [Depth];
  logic [31:0] bs_mem  [uhsr_pkg::SumDepth];
  logic [31:0] dly_rd_q;
  logic [15:0] wt_rd_q;
  logic [31:0] bs_rd_q;
  logic        bs_vld_q;

  logic             accept;
  logic             cell_ok;
  logic             last_slot;
  logic [5:0]       nsb_eff;
  logic [AddrW-1:0] load_addr;
  logic [AddrW-1:0] slot_addr;
  logic             dly_we;
  logic [AddrW-1:0] dly_wa;
  logic [31:0]      dly_wd;
  logic             wt_we;
  logic [AddrW-1:0] wt_wa;
  logic [15:0]      wt_wd;
  logic [5:0]       bs_ra;
  logic [31:0]      bs_val;
  logic [47:0]      product;
  logic [31:0]      slot_sum;

  assign accept    = in_valid_i && (state_q == uhsr_pkg::ST_IDLE);
  assign cell_ok   = 32'(cell_req_i) < CELLS;
  assign last_slot = jcnt_q == LagW'(LAGS - 1);
  assign nsb_eff   = (32'(nsb_q) > MAX_SUBBASINS) ? 6'(MAX_SUBBASINS) : nsb_q;
  assign load_addr = AddrW'(32'(cell_req_i) * LAGS + 32'(lag_i));
  assign slot_addr = base_q + AddrW'(jcnt_q);
  assign bs_val    = bs_vld_q ? bs_rd_q : 32'd0;
  assign product   = yld_q * wt_rd_q;
  assign slot_sum  = uhsr_pkg::sat_add(old_q, prod_q);
  assign bs_ra     = (state_q == uhsr_pkg::ST_BRD) ? sb_q : i_q;

  always_comb begin
    dly_we = 1'b0;
    dly_wa = slot_addr;
    dly_wd = slot_sum;
    wt_we  = 1'b0;
    wt_wa  = load_addr;
    wt_wd  = weight_i;
    if (state_q == uhsr_pkg::ST_CLR) begin
      dly_we = 1'b1;
      dly_wa = clr_q;
      dly_wd = 32'd0;
      wt_we  = 1'b1;
      wt_wa  = clr_q;
      wt_wd  = 16'd0;
    end else if (state_q == uhsr_pkg::ST_SWR) begin
      dly_we = 1'b1;
    end else if (accept && func_i == uhsr_pkg::FUNC_LOAD && cell_ok &&
                 32'(lag_i) < LAGS) begin
      wt_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_rd_q <= dly_mem[slot_addr + AddrW'(1)];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_wa] <= wt_wd;
    end
    wt_rd_q <= wt_mem[slot_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == uhsr_pkg::ST_BWR) begin
      bs_mem[sb_q] <= uhsr_pkg::sat_add(bs_val, head_q);
    end
    bs_rd_q <= bs_mem[bs_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_vld_q <= 1'b0;
    end else begin
      bs_vld_q <= bs_valid_q[bs_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= uhsr_pkg::ST_CLR;
      clr_q      <= '0;
      nsb_q      <= 6'd1;
      bs_valid_q <= '0;
      jcnt_q     <= '0;
      i_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        nsb_q <= cfg_data_i;
      end
      unique case (state_q)
        uhsr_pkg::ST_CLR: begin
          clr_q <= clr_q + AddrW'(1);
          if (32'(clr_q) == Depth - 1) begin
            state_q <= uhsr_pkg::ST_IDLE;
          end
        end
        uhsr_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (func_i)
              uhsr_pkg::FUNC_STEP: begin
                if (cell_ok) begin
                  base_q  <= AddrW'(32'(cell_req_i) * LAGS);
                  cell_q  <= cell_req_i;
                  sb_q    <= subbasin_i;
                  yld_q   <= sed_yield_i;
                  jcnt_q  <= '0;
                  state_q <= uhsr_pkg::ST_SRD;
                end
              end
              uhsr_pkg::FUNC_END: begin
                total_q <= 32'd0;
                i_q     <= 6'd1;
                if (nsb_eff == 6'd0) begin
                  kind_q   <= 1'b1;
                  index_q  <= 10'd0;
                  amount_q <= 32'd0;
                  last_q   <= 1'b1;
                  state_q  <= uhsr_pkg::ST_EMIT;
                end else begin
                  state_q <= uhsr_pkg::ST_TRD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        uhsr_pkg::ST_SRD: begin
          state_q <= uhsr_pkg::ST_SMUL;
        end
        uhsr_pkg::ST_SMUL: begin
          prod_q  <= product[47:16];
          old_q   <= last_slot ? 32'd0 : dly_rd_q;
          state_q <= uhsr_pkg::ST_SWR;
        end
        uhsr_pkg::ST_SWR: begin
          if (jcnt_q == '0) begin
            head_q <= slot_sum;
          end
          if (last_slot) begin
            kind_q   <= 1'b0;
            index_q  <= cell_q;
            amount_q <= (jcnt_q == '0) ? slot_sum : head_q;
            last_q   <= 1'b1;
            if (sb_q != 6'd0 && sb_q <= nsb_eff) begin
              state_q <= uhsr_pkg::ST_BRD;
            end else begin
              state_q <= uhsr_pkg::ST_EMIT;
            end
          end else begin
            jcnt_q  <= jcnt_q + LagW'(1);
            state_q <= uhsr_pkg::ST_SRD;
          end
        end
        uhsr_pkg::ST_BRD: begin
          state_q <= uhsr_pkg::ST_BWR;
        end
        uhsr_pkg::ST_BWR: begin
          bs_valid_q[sb_q] <= 1'b1;
          state_q          <= uhsr_pkg::ST_EMIT;
        end
        uhsr_pkg::ST_TRD: begin
          state_q <= uhsr_pkg::ST_TACC;
        end
        uhsr_pkg::ST_TACC: begin
          if (i_q == nsb_eff) begin
            kind_q   <= 1'b1;
            index_q  <= 10'd0;
            amount_q <= uhsr_pkg::sat_add(total_q, bs_val);
            last_q   <= 1'b0;
            state_q  <= uhsr_pkg::ST_EMIT;
          end else begin
            total_q <= uhsr_pkg::sat_add(total_q, bs_val);
            i_q     <= i_q + 6'd1;
            state_q <= uhsr_pkg::ST_TRD;
          end
        end
        uhsr_pkg::ST_ORD: begin
          state_q <= uhsr_pkg::ST_OLD;
        end
        uhsr_pkg::ST_OLD: begin
          kind_q   <= 1'b1;
          index_q  <= 10'(i_q);
          amount_q <= bs_val;
          last_q   <= i_q == nsb_eff;
          state_q  <= uhsr_pkg::ST_EMIT;
        end
        uhsr_pkg::ST_EMIT: begin
          if (!out_stall_i) begin
            if (!kind_q) begin
              state_q <= uhsr_pkg::ST_IDLE;
            end else if (last_q) begin
              bs_valid_q <= '0;
              state_q    <= uhsr_pkg::ST_IDLE;
            end else begin
              i_q     <= index_q[5:0] + 6'd1;
              state_q <= uhsr_pkg::ST_ORD;
            end
          end
        end
        default: begin
          state_q <= uhsr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != uhsr_pkg::ST_IDLE;
  assign out_valid_o = state_q == uhsr_pkg::ST_EMIT;
  assign kind_o      = kind_q;
  assign index_o     = index_q;
  assign amount_o    = amount_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_cell_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> last_o)
    else $error("cell result without last");

  a_sum_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o && !last_o) |-> (index_o < 10'(nsb_eff)))
    else $error("sum transaction index beyond subbasin count");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(index_o)))
    else $error("stalled result changed");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unit hydrograph sediment router testbench
// Drives weight loads, cell steps and end-of-step items with random gaps and
// output stalls, predicts every head and basin sum, and checks each result.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        kind;
  logic [9:0]  index;
  logic [31:0] amount;
  logic        last;
} route_res_t;

class route_scoreboard;
  logic [31:0] delay_line [1024*32];
  logic [15:0] uh_weight [1024*32];
  logic [31:0] basin_acc [64];
  logic [5:0]  nsb_reg;
  route_res_t  pending [$];
  int          errors;
  int          seen;

  function new();
    foreach (delay_line[i]) delay_line[i] = '0;
    foreach (uh_weight[i]) uh_weight[i] = '0;
    foreach (basin_acc[i]) basin_acc[i] = '0;
    nsb_reg = 6'd1;
    errors = 0;
    seen = 0;
  endfunction

  function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function void note_item(uhsr_pkg::func_e f, logic [9:0] cell_idx, logic [4:0] lag,
                          logic [15:0] wt, logic [5:0] sb, logic [31:0] yld);
    int base;
    int n;
    logic [31:0] tot;
    logic [47:0] p;
    route_res_t r;
    n = (nsb_reg > 63) ? 63 : nsb_reg;
    base = cell_idx * 32;
    if (f == uhsr_pkg::FUNC_LOAD) begin
      uh_weight[base + lag] = wt;
    end else if (f == uhsr_pkg::FUNC_STEP) begin
      for (int j = 0; j < 31; j++) delay_line[base + j] = delay_line[base + j + 1];
      delay_line[base + 31] = '0;
      for (int j = 0; j < 32; j++) begin
        p = yld * uh_weight[base + j];
        delay_line[base + j] = add_sat(delay_line[base + j], p[47:16]);
      end
      if (sb >= 1 && sb <= n) basin_acc[sb] = add_sat(basin_acc[sb], delay_line[base]);
      r = '{1'b0, cell_idx, delay_line[base], 1'b1};
      pending.push_back(r);
    end else if (f == uhsr_pkg::FUNC_END) begin
      tot = '0;
      for (int i = 1; i <= n; i++) tot = add_sat(tot, basin_acc[i]);
      r = '{1'b1, 10'd0, tot, n == 0};
      pending.push_back(r);
      for (int i = 1; i <= n; i++) begin
        r = '{1'b1, 10'(i), basin_acc[i], i == n};
        pending.push_back(r);
      end
      foreach (basin_acc[i]) basin_acc[i] = '0;
    end
  endfunction

  function void check_result(route_res_t got);
    route_res_t want;
    seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.kind !== want.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.index !== want.index) begin
      $display("%0t: index expected %0d actual %0d", $time, want.index, got.index);
      errors++;
    end
    if (got.amount !== want.amount) begin
      $display("%0t: amount expected %h actual %h", $time, want.amount, got.amount);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [9:0]  cell_req_i = '0;
  logic [4:0]  lag_i = '0;
  logic [15:0] weight_i = '0;
  logic [5:0]  subbasin_i = '0;
  logic [31:0] sed_yield_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [9:0]  index_o;
  logic [31:0] amount_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_data_i = '0;

  route_scoreboard sb = new();
  int  cycles = 0;
  int  items = 0;
  int  stall_mode = 0;
  localparam int CycleLimit = 2_000_000;

  unit_hydrograph_sediment_router i_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{kind_o, index_o, amount_o, last_o});
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_item(uhsr_pkg::func_e f, logic [9:0] cell_idx, logic [4:0] lag,
                           logic [15:0] wt, logic [5:0] sbi, logic [31:0] yld);
    func_i <= f;
    cell_req_i <= cell_idx;
    lag_i <= lag;
    weight_i <= wt;
    subbasin_i <= sbi;
    sed_yield_i <= yld;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(f, cell_idx, lag, wt, sbi, yld);
    items++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_set(logic [5:0] nsb);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_data_i <= nsb;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.nsb_reg = nsb;
  endtask

  task automatic random_phase(int count, logic [5:0] nsb);
    int burst;
    int r;
    logic [9:0] cell_idx;
    logic [31:0] yld;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
        burst = $urandom_range(1, 12);
      end
      burst--;
      cell_idx = 10'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) cell_idx = 10'($urandom);
      yld = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000F_FFFF);
      r = $urandom_range(0, 19);
      if (r < 7) send_item(uhsr_pkg::FUNC_LOAD, cell_idx, 5'($urandom), 16'($urandom),
                           6'($urandom), $urandom);
      else if (r < 16) send_item(uhsr_pkg::FUNC_STEP, cell_idx, 5'($urandom), 16'($urandom),
                                 6'($urandom_range(0, nsb + 1)), yld);
      else if (r < 18) send_item(uhsr_pkg::FUNC_END, 10'($urandom), 5'($urandom),
                                 16'($urandom), 6'($urandom), $urandom);
      else send_item(uhsr_pkg::FUNC_NONE, 10'($urandom), 5'($urandom), 16'($urandom),
                     6'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(uhsr_pkg::FUNC_STEP, 10'd0, 5'd0, 16'd0, 6'd1, 32'h1234_5678);
    send_item(uhsr_pkg::FUNC_END, 10'd0, 5'd0, 16'd0, 6'd0, 32'd0);
    send_item(uhsr_pkg::FUNC_LOAD, 10'd1, 5'd0, 16'hFFFF, 6'd0, 32'd0);
    send_item(uhsr_pkg::FUNC_LOAD, 10'd1, 5'd1, 16'h8000, 6'd0, 32'd0);
    send_item(uhsr_pkg::FUNC_LOAD, 10'd1, 5'd31, 16'h0001, 6'd0, 32'd0);
    send_item(uhsr_pkg::FUNC_STEP, 10'd1, 5'd0, 16'd0, 6'd1, 32'hFFFF_FFFF);
    send_item(uhsr_pkg::FUNC_STEP, 10'd1, 5'd0, 16'd0, 6'd1, 32'hFFFF_FFFF);
    send_item(uhsr_pkg::FUNC_STEP, 10'd1, 5'd0, 16'd0, 6'd0, 32'd0);
    send_item(uhsr_pkg::FUNC_LOAD, 10'd1023, 5'd31, 16'hFFFF, 6'd0, 32'd0);
    send_item(uhsr_pkg::FUNC_STEP, 10'd1023, 5'd0, 16'd0, 6'd63, 32'hFFFF_FFFF);
    send_item(uhsr_pkg::FUNC_NONE, 10'd1, 5'd1, 16'hFFFF, 6'd1, 32'hFFFF_FFFF);
    send_item(uhsr_pkg::FUNC_END, 10'd0, 5'd0, 16'd0, 6'd0, 32'd0);
    drain_and_set(6'd63);
    send_item(uhsr_pkg::FUNC_STEP, 10'd1, 5'd0, 16'd0, 6'd63, 32'hFFFF_FFFF);
    send_item(uhsr_pkg::FUNC_STEP, 10'd1023, 5'd0, 16'd0, 6'd63, 32'hFFFF_FFFF);
    send_item(uhsr_pkg::FUNC_END, 10'd0, 5'd0, 16'd0, 6'd0, 32'd0);
    drain_and_set(6'd0);
    send_item(uhsr_pkg::FUNC_STEP, 10'd1, 5'd0, 16'd0, 6'd1, 32'h0001_0000);
    send_item(uhsr_pkg::FUNC_END, 10'd0, 5'd0, 16'd0, 6'd0, 32'd0);

    drain_and_set(6'd3);
    random_phase(140, 6'd3);
    drain_and_set(6'd63);
    random_phase(120, 6'd63);
    drain_and_set(6'd1);
    random_phase(90, 6'd1);
    drain_and_set(6'd0);
    random_phase(60, 6'd0);

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    $display("Sent %0d transactions over four basin counts; checked %0d results.",
             items, sb.seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/uhsr_pkg.sv
rtl/unit_hydrograph_sediment_router.sv
test/testbench.sv
